// ===== rtl/hysteresis_frequency_meter_defines.svh =====
// ----------------------------------------------------------------------------
// Hysteresis frequency meter assertion macros
// Shared property forms for the checks on the top level.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_FREQUENCY_METER_DEFINES_SVH
`define HYSTERESIS_FREQUENCY_METER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define HFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Hysteresis frequency meter package
// Shared types, register indexes and field layout.
// ----------------------------------------------------------------------------
package hfm_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int THRESH_W    = 12;
  localparam int TIME_W      = 32;
  localparam int FREQ_W      = 28;
  localparam int CFG_INDEX_W = 1;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 32;
  localparam int TIME_LSB  = SAMPLE_W;

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT = 1'd1;

  localparam logic [THRESH_W-1:0] UPPER_LIMIT_RESET = 12'd2100;
  localparam logic [THRESH_W-1:0] LOWER_LIMIT_RESET = 12'd1900;

  localparam int MICROS_PER_SECOND = 1000000;
  localparam int MICROS_W          = 20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/hysteresis_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// Hysteresis frequency meter
// Schmitt comparator on converter samples with reciprocal frequency readout.
// ----------------------------------------------------------------------------
// Each request carries a sample and its microsecond timestamp and yields one
// result: comparator level, rising-crossing flag and the current frequency in
// hertz with FRACTION_BITS fraction bits. A request that produces a new
// measurement runs through the restoring divider, which forms one quotient
// bit per cycle; one that does not goes straight to the result stage. A
// finished result waits in the output register until taken.
module hysteresis_frequency_meter #(
  parameter int TIME_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hfm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hfm_pkg::THRESH_W-1:0]    cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sample [11:0], time_us [43:12], zero fill [47:44]
  input  logic [hfm_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // level_high [0], rising_crossing [1], frequency_q8 [29:2], zero fill [31:30]
  output logic [hfm_pkg::M_TDATA_W-1:0]   m_tdata
);

`include "hysteresis_frequency_meter_defines.svh"

  hfm_pkg::ctrl_cmd_t  cmd;
  hfm_pkg::dp_status_t status;

  hfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hfm_datapath #(
    .TIME_BITS     (TIME_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

  `HFM_ASSERT_NOW(a_rise_implies_high, m_tvalid && m_tdata[1], m_tdata[0], "crossing with low level")
  `HFM_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `HFM_ASSERT_NOW(a_commit_slot_free, cmd.commit, !m_tvalid || m_tready, "result overwritten")

endmodule

// ===== rtl/hfm_datapath.sv =====
// ----------------------------------------------------------------------------
// Hysteresis frequency meter datapath
// Thresholds, comparator, crossing time, restoring divider and result register.
// ----------------------------------------------------------------------------
module hfm_datapath #(
  parameter int TIME_BITS     = 32,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hfm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [hfm_pkg::THRESH_W-1:0]         cfg_data,
  input  logic [hfm_pkg::S_TDATA_W-1:0]        s_tdata,
  input  hfm_pkg::ctrl_cmd_t                   cmd,
  output hfm_pkg::dp_status_t                  status,
  output logic [hfm_pkg::M_TDATA_W-1:0]        m_tdata
);

  localparam int DW = hfm_pkg::MICROS_W + FRACTION_BITS;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] DIVIDEND = DW'(64'(hfm_pkg::MICROS_PER_SECOND) << FRACTION_BITS);
  localparam logic [CW-1:0] CNT_START = CW'(DW - 1);

  logic [hfm_pkg::THRESH_W-1:0] upper_limit;
  logic [hfm_pkg::THRESH_W-1:0] lower_limit;
  logic                         level;
  logic [TIME_BITS-1:0]         last_time;
  logic [hfm_pkg::FREQ_W-1:0]   frequency;
  logic                         rise_hold;
  logic                         update;
  logic [TIME_BITS-1:0]         period;
  logic [TIME_BITS-1:0]         rem;
  logic [DW-1:0]                quot;
  logic [CW-1:0]                cnt;
  logic                         out_level;
  logic                         out_rise;
  logic [hfm_pkg::FREQ_W-1:0]   out_freq;

  logic [hfm_pkg::SAMPLE_W-1:0] sample;
  logic [TIME_BITS-1:0]         now;
  logic [TIME_BITS-1:0]         period_now;
  logic                         rise;
  logic                         fall;
  logic [TIME_BITS:0]           trial;
  logic                         ge;
  logic [TIME_BITS:0]           diff;
  logic [31:0]                  quot_ext;
  logic [hfm_pkg::FREQ_W-1:0]   freq_new;
  logic [hfm_pkg::FREQ_W-1:0]   freq_next;

  always_comb begin
    sample     = s_tdata[hfm_pkg::SAMPLE_W-1:0];
    now        = s_tdata[hfm_pkg::TIME_LSB +: TIME_BITS];
    period_now = now - last_time;
    rise       = !level && (sample > upper_limit);
    fall       = level && (sample < lower_limit);
    status.need_div = rise && (last_time != '0) && (period_now != '0);
    status.div_last = (cnt == '0);
    trial = {rem, DIVIDEND[cnt]};
    ge    = trial >= {1'b0, period};
    diff  = trial - {1'b0, period};
    quot_ext = 32'(quot);
    freq_new = (quot_ext > 32'(hfm_pkg::FREQ_MAX)) ? hfm_pkg::FREQ_MAX
                                                   : quot_ext[hfm_pkg::FREQ_W-1:0];
    freq_next = update ? freq_new : frequency;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= hfm_pkg::UPPER_LIMIT_RESET;
      lower_limit <= hfm_pkg::LOWER_LIMIT_RESET;
      level       <= 1'b0;
      last_time   <= '0;
      frequency   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hfm_pkg::REG_UPPER_LIMIT: upper_limit <= cfg_data;
          hfm_pkg::REG_LOWER_LIMIT: lower_limit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (rise) begin
          level     <= 1'b1;
          last_time <= now;
        end else if (fall) begin
          level <= 1'b0;
        end
      end
      if (cmd.commit) begin
        frequency <= freq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rise_hold <= rise;
      update    <= status.need_div;
      period    <= period_now;
      rem       <= '0;
      quot      <= '0;
      cnt       <= CNT_START;
    end else if (cmd.step) begin
      rem  <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quot <= {quot[DW-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
    if (cmd.commit) begin
      out_level <= level;
      out_rise  <= rise_hold;
      out_freq  <= freq_next;
    end
  end

  assign m_tdata = {2'b00, out_freq, out_rise, out_level};

endmodule

// ===== rtl/hfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hysteresis frequency meter controller
// Sequences request intake, divider steps and result hand-off.
// ----------------------------------------------------------------------------
module hfm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  hfm_pkg::dp_status_t status,
  output hfm_pkg::ctrl_cmd_t  cmd
);

  hfm_pkg::state_t state;
  hfm_pkg::state_t state_next;
  logic            m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hfm_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      hfm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = status.need_div ? hfm_pkg::ST_DIVIDE : hfm_pkg::ST_DONE;
        end
      end
      hfm_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_next = hfm_pkg::ST_DONE;
        end
      end
      hfm_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.commit = 1'b1;
          state_next = hfm_pkg::ST_IDLE;
        end
      end
      default: state_next = hfm_pkg::ST_IDLE;
    endcase
    m_tvalid_next = cmd.commit || (m_tvalid && !m_tready);
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Hysteresis frequency meter testbench
// Drives sample requests into the meter and checks every result against a
// local model of the comparator, the crossing timestamp and the divider.
// A directed part covers the threshold edges, the first crossing, zero and
// wrapped periods and extreme thresholds. Random phases then send clean
// waveforms and noise under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRACTION_BITS = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;
  localparam int SAMPLE_MAX = (1 << hfm_pkg::SAMPLE_W) - 1;

  typedef struct packed {
    logic                       level_high;
    logic                       rising;
    logic [hfm_pkg::FREQ_W-1:0] freq;
  } meter_result_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [hfm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [hfm_pkg::THRESH_W-1:0]    cfg_data;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [hfm_pkg::S_TDATA_W-1:0]   s_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [hfm_pkg::M_TDATA_W-1:0]   m_tdata;

  logic [hfm_pkg::THRESH_W-1:0] thresh_high;
  logic [hfm_pkg::THRESH_W-1:0] thresh_low;
  logic                         level_q;
  logic [hfm_pkg::TIME_W-1:0]   last_cross;
  logic [hfm_pkg::FREQ_W-1:0]   freq_q;

  meter_result_t pending_results[$];
  meter_result_t got;
  meter_result_t want;

  int          errors;
  int          items_sent;
  int          idle_cycles;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  logic [hfm_pkg::TIME_W-1:0] wave_cross;

  hysteresis_frequency_meter #(
    .TIME_BITS     (hfm_pkg::TIME_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic meter_result_t measure_sample(
      input logic [hfm_pkg::SAMPLE_W-1:0] smp,
      input logic [hfm_pkg::TIME_W-1:0] ts);
    meter_result_t              r;
    logic [hfm_pkg::TIME_W-1:0] period;
    logic [63:0]                q;
    r.rising = 1'b0;
    if (!level_q && smp > thresh_high) begin
      level_q = 1'b1;
      r.rising = 1'b1;
      if (last_cross != '0) begin
        period = ts - last_cross;
        if (period != '0) begin
          q = (64'(hfm_pkg::MICROS_PER_SECOND) << FRACTION_BITS) / 64'(period);
          freq_q = (q > 64'(hfm_pkg::FREQ_MAX)) ? hfm_pkg::FREQ_MAX
                                                : q[hfm_pkg::FREQ_W-1:0];
        end
      end
      last_cross = ts;
    end else if (level_q && smp < thresh_low) begin
      level_q = 1'b0;
    end
    r.level_high = level_q;
    r.freq = freq_q;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // receiver side
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.level_high = m_tdata[0];
      got.rising = m_tdata[1];
      got.freq = m_tdata[2 +: hfm_pkg::FREQ_W];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
      end else begin
        want = pending_results.pop_front();
        compare_field("level_high", 32'(want.level_high), 32'(got.level_high));
        compare_field("rising_crossing", 32'(want.rising), 32'(got.rising));
        compare_field("frequency_q8", 32'(want.freq), 32'(got.freq));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [hfm_pkg::SAMPLE_W-1:0] smp,
                             input logic [hfm_pkg::TIME_W-1:0] ts);
    logic [hfm_pkg::S_TDATA_W-1:0] word;
    word = '0;
    word[hfm_pkg::SAMPLE_W-1:0] = smp;
    word[hfm_pkg::TIME_LSB +: hfm_pkg::TIME_W] = ts;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(measure_sample(smp, ts));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [hfm_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [hfm_pkg::THRESH_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == hfm_pkg::REG_UPPER_LIMIT)
      thresh_high = value;
    else
      thresh_low = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [hfm_pkg::SAMPLE_W-1:0] low_sample();
    if (thresh_low == '0) return '0;
    return hfm_pkg::SAMPLE_W'($urandom_range(int'(thresh_low) - 1, 0));
  endfunction

  function automatic logic [hfm_pkg::SAMPLE_W-1:0] high_sample();
    if (int'(thresh_high) >= SAMPLE_MAX) return hfm_pkg::SAMPLE_W'(SAMPLE_MAX);
    return hfm_pkg::SAMPLE_W'($urandom_range(SAMPLE_MAX, int'(thresh_high) + 1));
  endfunction

  function automatic logic [hfm_pkg::SAMPLE_W-1:0] band_sample();
    if (thresh_low > thresh_high) return high_sample();
    return hfm_pkg::SAMPLE_W'($urandom_range(int'(thresh_high), int'(thresh_low)));
  endfunction

  // low stretch, rising edge at the next crossing time, then high or in-band samples
  task automatic send_wave(input int periods);
    int unsigned                pick;
    logic [hfm_pkg::TIME_W-1:0] step;
    repeat (periods) begin
      repeat ($urandom_range(3, 1)) send_sample(low_sample(), $urandom);
      pick = $urandom_range(99);
      if (pick < 5)
        step = '0;
      else if (pick < 10)
        step = $urandom;
      else if (pick < 25)
        step = $urandom_range(255, 1);
      else
        step = $urandom_range(100000, 1);
      wave_cross += step;
      send_sample(high_sample(), wave_cross);
      repeat ($urandom_range(3, 0)) begin
        if ($urandom_range(1))
          send_sample(band_sample(), $urandom);
        else
          send_sample(high_sample(), $urandom);
      end
    end
  endtask

  task automatic send_noise(input int count);
    int smp;
    repeat (count) begin
      case ($urandom_range(2))
        0: smp = int'(thresh_high) + $urandom_range(2) - 1;
        1: smp = int'(thresh_low) + $urandom_range(2) - 1;
        default: smp = $urandom_range(SAMPLE_MAX);
      endcase
      if (smp < 0) smp = 0;
      if (smp > SAMPLE_MAX) smp = SAMPLE_MAX;
      send_sample(hfm_pkg::SAMPLE_W'(smp), $urandom);
    end
  endtask

  task automatic run_random(input int count, input int unsigned idle_pct,
                            input int unsigned stall_pct,
                            input logic [hfm_pkg::THRESH_W-1:0] hi,
                            input logic [hfm_pkg::THRESH_W-1:0] lo);
    int target;
    wait_drained();
    write_threshold(hfm_pkg::REG_UPPER_LIMIT, hi);
    write_threshold(hfm_pkg::REG_LOWER_LIMIT, lo);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    wave_cross = $urandom;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70)
        send_wave($urandom_range(8, 1));
      else
        send_noise($urandom_range(6, 1));
    end
  endtask

  task automatic test_directed_crossings();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_sample(12'd0, 32'd0);
    send_sample(12'd2100, 32'd5);
    // rising at time zero: store only
    send_sample(12'd2101, 32'd0);
    send_sample(12'd1900, 32'd10);
    send_sample(12'd1899, 32'd20);
    // previous crossing at zero counts as none
    send_sample(12'd4095, 32'd1000);
    send_sample(12'd0, 32'd1100);
    send_sample(12'hAAA, 32'd2000);
    send_sample(12'h555, 32'd2100);
    // one microsecond period
    send_sample(12'd4095, 32'd2001);
    send_sample(12'd0, 32'd2050);
    // zero period
    send_sample(12'd4095, 32'd2001);
    send_sample(12'd0, 32'hAAAA_AAAA);
    send_sample(12'd4095, 32'hFFFF_FFFF);
    send_sample(12'd0, 32'h5555_5555);
    // wrapped timestamp
    send_sample(12'd4095, 32'h0000_03E7);
  endtask

  task automatic test_threshold_extremes();
    wait_drained();
    write_threshold(hfm_pkg::REG_UPPER_LIMIT, 12'd0);
    write_threshold(hfm_pkg::REG_LOWER_LIMIT, 12'd4095);
    send_sample(12'd0, 32'd5000);
    send_sample(12'd0, 32'd5001);
    send_sample(12'd1, 32'd6000);
    send_sample(12'd4094, 32'd6100);
    send_sample(12'd4095, 32'd7000);
    send_sample(12'd4095, 32'd7100);
    wait_drained();
    write_threshold(hfm_pkg::REG_UPPER_LIMIT, 12'd4095);
    write_threshold(hfm_pkg::REG_LOWER_LIMIT, 12'd0);
    send_sample(12'd0, 32'd8000);
    wait_drained();
    write_threshold(hfm_pkg::REG_LOWER_LIMIT, 12'd1);
    send_sample(12'd0, 32'd8100);
    send_sample(12'd4095, 32'd9000);
    send_sample(12'd0, 32'd9100);
  endtask

  task automatic test_random_no_idle();
    run_random(480, 0, 0, hfm_pkg::UPPER_LIMIT_RESET, hfm_pkg::LOWER_LIMIT_RESET);
  endtask

  task automatic test_random_sender_idle();
    int hi;
    hi = $urandom_range(4000, 2048);
    run_random(480, 79, 0, hfm_pkg::THRESH_W'(hi),
               hfm_pkg::THRESH_W'($urandom_range(hi, 100)));
  endtask

  task automatic test_random_receiver_stall();
    run_random(480, 0, 79, 12'd2048, 12'd2048);
  endtask

  task automatic test_random_both_idle();
    int hi;
    hi = $urandom_range(2000, 100);
    run_random(480, 10, 10, hfm_pkg::THRESH_W'(hi),
               hfm_pkg::THRESH_W'($urandom_range(4000, hi + 1)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wave_cross = '0;
    thresh_high = hfm_pkg::UPPER_LIMIT_RESET;
    thresh_low = hfm_pkg::LOWER_LIMIT_RESET;
    level_q = 1'b0;
    last_cross = '0;
    freq_q = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_crossings();
    test_threshold_extremes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_drained();

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hfm_pkg.sv
rtl/hfm_datapath.sv
rtl/hfm_ctrl.sv
rtl/hysteresis_frequency_meter.sv
bench/testbench.sv
